>>> rtl/fvcs_pkg.sv
// ----------------------------------------------------------------------------
// fvcs_pkg
// Shared types and constants for the FIFO vertex cache simulator.
// ----------------------------------------------------------------------------
package fvcs_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 32;
   localparam int CSR_SIZE_W          = 6;
   localparam int CSR_SIZE_RESET      = 32;
   localparam int MIN_ENTRIES         = 4;
   localparam int VERTEX_W            = 31;
   localparam int COUNT_W             = 32;
   localparam int VERTICES_PER_FACE   = 3;

   // operation codes
   localparam logic OP_FACE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [VERTEX_W-1:0] first_vertex;
      logic [VERTEX_W-1:0] second_vertex;
      logic [VERTEX_W-1:0] third_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0]         face_hits;
      logic [1:0]         face_misses;
      logic [COUNT_W-1:0] hit_total;
      logic [COUNT_W-1:0] miss_total;
      logic [COUNT_W-1:0] face_total;
   } rsp_type;

   // control from the sequencer to the cache array
   typedef struct packed {
      logic clear;
      logic lookup;
   } cache_cmd_type;

endpackage

>>> rtl/fvcs_cache.sv
// ----------------------------------------------------------------------------
// fvcs_cache
// FIFO cache array: one lookup per cycle against all active entries; a miss
// shifts the entries back by one place and inserts the vertex at the front.
// ----------------------------------------------------------------------------
module fvcs_cache
   import fvcs_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT,
   parameter int ACT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  cache_cmd_type       cmd,
   input  logic [VERTEX_W-1:0] vertex,
   input  logic [ACT_W-1:0]    active_size,
   output logic                hit
);

   logic [VERTEX_W-1:0] entry_vertex_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] entry_valid_ff;
   logic [MAX_ENTRIES-1:0] entry_valid_in;
   logic [MAX_ENTRIES-1:0] match;

   // parallel tag compare over the active entries
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i] = entry_valid_ff[i] && (entry_vertex_ff[i] == vertex) &&
                    (ACT_W'(i) < active_size);
      end
   end

   assign hit = |match;

   // valid bits: cleared by reset or clear, shifted on a miss
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (cmd.clear) begin
         entry_valid_in = '0;
      end else if (cmd.lookup && !hit) begin
         entry_valid_in = {entry_valid_ff[MAX_ENTRIES-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   // vertex shift line, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.lookup && !hit && !cmd.clear) begin
         entry_vertex_ff[0] <= vertex;
         for (int i = 1; i < MAX_ENTRIES; i++) begin
            entry_vertex_ff[i] <= entry_vertex_ff[i-1];
         end
      end
   end

endmodule

>>> rtl/fifo_vertex_cache_simulator_top.sv
// ----------------------------------------------------------------------------
// A face transaction looks up its three vertices one after another, then a
// result step loads the output register; a clear goes straight to the result
// step. req_stall holds off new requests until the result step is done; that
// step waits while the output register still holds a stalled result. The
// single cache lookup/shift unit is reused for each vertex in turn.
// Reset: synchronous, active high; empties the cache, zeroes the totals and
// sets the cache size register to 32, which is in effect at once.
// ----------------------------------------------------------------------------
// fifo_vertex_cache_simulator_top
// Sequencer, totals and result register around the FIFO cache array.
// ----------------------------------------------------------------------------
module fifo_vertex_cache_simulator_top
   import fvcs_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_SIZE_W-1:0] csr_wr_data
);

   localparam int ACT_W        = $clog2(MAX_ENTRIES + 1);
   localparam int ACTIVE_RESET = (CSR_SIZE_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CSR_SIZE_RESET;
   localparam logic [1:0] LAST_STEP = 2'(VERTICES_PER_FACE - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_POST = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] step_ff, step_in;
   req_type req_ff, req_in;
   logic [1:0] face_hits_ff, face_hits_in;
   logic clear_op_ff, clear_op_in;
   logic [COUNT_W-1:0] hit_total_ff, hit_total_in;
   logic [COUNT_W-1:0] miss_total_ff, miss_total_in;
   logic [COUNT_W-1:0] face_total_ff, face_total_in;
   logic [ACT_W-1:0] active_ff, active_in;
   logic [CSR_SIZE_W-1:0] csr_size_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic [CSR_SIZE_W:0] csr_ext;
   logic [ACT_W-1:0] active_clamped;
   logic [VERTEX_W-1:0] vertex_sel;
   cache_cmd_type cache_cmd;
   logic cache_hit;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // size clamp applied when a clear latches the register
   always_comb begin
      csr_ext = {1'b0, csr_size_ff};
      if (csr_ext < (CSR_SIZE_W+1)'(MIN_ENTRIES)) begin
         active_clamped = ACT_W'(MIN_ENTRIES);
      end else if (csr_ext > (CSR_SIZE_W+1)'(MAX_ENTRIES)) begin
         active_clamped = ACT_W'(MAX_ENTRIES);
      end else begin
         active_clamped = ACT_W'(csr_ext);
      end
   end

   // vertex for the current lookup step
   always_comb begin
      case (step_ff)
         2'd0:    vertex_sel = req_ff.first_vertex;
         2'd1:    vertex_sel = req_ff.second_vertex;
         default: vertex_sel = req_ff.third_vertex;
      endcase
   end

   assign cache_cmd.clear  = req_accept && (req_data.operation == OP_CLEAR);
   assign cache_cmd.lookup = (state_ff == ST_LOOK);

   fvcs_cache #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ACT_W       (ACT_W)
   ) u_cache (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cache_cmd),
      .vertex      (vertex_sel),
      .active_size (active_ff),
      .hit         (cache_hit)
   );

   // sequencer and totals
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      req_in        = req_ff;
      face_hits_in  = face_hits_ff;
      clear_op_in   = clear_op_ff;
      hit_total_in  = hit_total_ff;
      miss_total_in = miss_total_ff;
      face_total_in = face_total_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in       = req_data;
               step_in      = '0;
               face_hits_in = '0;
               if (req_data.operation == OP_CLEAR) begin
                  clear_op_in   = 1'b1;
                  hit_total_in  = '0;
                  miss_total_in = '0;
                  face_total_in = '0;
                  active_in     = active_clamped;
                  state_in      = ST_POST;
               end else begin
                  clear_op_in = 1'b0;
                  if (face_total_ff != COUNT_MAX) begin
                     face_total_in = face_total_ff + 1'b1;
                  end
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (cache_hit) begin
               face_hits_in = face_hits_ff + 1'b1;
               if (hit_total_ff != COUNT_MAX) begin
                  hit_total_in = hit_total_ff + 1'b1;
               end
            end else if (miss_total_ff != COUNT_MAX) begin
               miss_total_in = miss_total_ff + 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.face_hits = face_hits_ff;
               rsp_data_in.face_misses =
                  clear_op_ff ? 2'd0 : 2'(VERTICES_PER_FACE) - face_hits_ff;
               rsp_data_in.hit_total  = hit_total_ff;
               rsp_data_in.miss_total = miss_total_ff;
               rsp_data_in.face_total = face_total_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         face_hits_ff  <= '0;
         clear_op_ff   <= 1'b0;
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
         face_total_ff <= '0;
         active_ff     <= ACT_W'(ACTIVE_RESET);
         csr_size_ff   <= CSR_SIZE_W'(CSR_SIZE_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         face_hits_ff  <= face_hits_in;
         clear_op_ff   <= clear_op_in;
         hit_total_ff  <= hit_total_in;
         miss_total_ff <= miss_total_in;
         face_total_ff <= face_total_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_size_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
